FILE: hw/rtl/mbid_pkg.sv
// Package: types, opcode codes and decode tables for the block instruction decoder.
`timescale 1ns / 1ps

package mbid_pkg;

    localparam int INSTR_W = 32;
    localparam int ADDR_W  = 29;
    localparam int OP_W    = 7;
    localparam int REG_W   = 5;
    localparam int SEL_W   = 6;
    localparam int SHIFT_W = 4;

    localparam int BLOCK_SPAN_BYTES_DEFAULT = 256;
    localparam int FETCH_STEP = 4;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_NONE    = 7'd0;
    localparam op_t OP_J       = 7'd1;
    localparam op_t OP_JAL     = 7'd2;
    localparam op_t OP_BEQ     = 7'd3;
    localparam op_t OP_BGTZ    = 7'd6;
    localparam op_t OP_SLTIU   = 7'd10;
    localparam op_t OP_ANDI    = 7'd11;
    localparam op_t OP_LUI     = 7'd14;
    localparam op_t OP_COP1    = 7'd15;
    localparam op_t OP_INVALID = 7'd17;
    localparam op_t OP_LB      = 7'd18;
    localparam op_t OP_SWC3    = 7'd37;
    localparam op_t OP_JR      = 7'd44;
    localparam op_t OP_BREAK   = 7'd47;
    localparam op_t OP_BLTZ    = 7'd66;
    localparam op_t OP_BGEZ    = 7'd67;
    localparam op_t OP_BLTZAL  = 7'd68;
    localparam op_t OP_BGEZAL  = 7'd69;
    localparam op_t OP_RFE     = 7'd72;

    localparam logic [5:0] MAJOR_SPECIAL = 6'h00;
    localparam logic [5:0] MAJOR_REGIMM  = 6'h01;
    localparam logic [5:0] MAJOR_COP0    = 6'h10;
    localparam logic [5:0] MAJOR_COP2    = 6'h12;
    localparam logic [4:0] RT_BLTZAL     = 5'h10;
    localparam logic [4:0] RT_BGEZAL     = 5'h11;
    localparam logic [5:0] FUNCT_RFE     = 6'h10;
    localparam logic [SHIFT_W-1:0] GTE_SF_SHIFT = 4'd12;

    localparam op_t PRIMARY_OPS [64] = '{
         0,  0,  1,  2,  3,  4,  5,  6,   7,  8,  9, 10, 11, 12, 13, 14,
         0, 15,  0, 16, 17, 17, 17, 17,  17, 17, 17, 17, 17, 17, 17, 17,
        18, 19, 20, 21, 22, 23, 24, 17,  25, 26, 27, 28, 17, 17, 29, 17,
        30, 31, 32, 33, 17, 17, 17, 17,  34, 35, 36, 37, 17, 17, 17, 17
    };

    localparam op_t SPECIAL_OPS [64] = '{
        38, 17, 39, 40, 41, 17, 42, 43,  44, 45, 17, 17, 46, 47, 17, 17,
        48, 49, 50, 51, 17, 17, 17, 17,  52, 53, 54, 55, 17, 17, 17, 17,
        56, 57, 58, 59, 60, 61, 62, 63,  17, 17, 64, 65, 17, 17, 17, 17,
        17, 17, 17, 17, 17, 17, 17, 17,  17, 17, 17, 17, 17, 17, 17, 17
    };

    localparam op_t COP0_MOVE_OPS [16] = '{
        70, 17, 17, 17, 71, 17, 17, 17,  17, 17, 17, 17, 17, 17, 17, 17
    };

    localparam op_t COP2_MOVE_OPS [16] = '{
        73, 17, 74, 17, 75, 17, 76, 17,  17, 17, 17, 17, 17, 17, 17, 17
    };

    localparam op_t COP2_CMD_OPS [64] = '{
        77, 77,  0,  0,  0,  0, 78,  0,   0,  0,  0,  0, 79,  0,  0,  0,
        80, 81, 82, 83, 84,  0, 85,  0,   0,  0, 86, 87, 88,  0, 89,  0,
        90,  0,  0,  0,  0,  0,  0,  0,  91, 86, 92,  0,  0, 93, 94,  0,
        95,  0,  0,  0,  0,  0,  0,  0,   0,  0,  0,  0,  0, 96, 97, 98
    };

    typedef struct packed {
        op_t                op;
        logic [INSTR_W-1:0] immediate;
        logic               changes_flow;
    } dec_t;

endpackage

FILE: hw/rtl/mbid_decode.sv
// Combinational decode of one instruction word into op number, immediate and flow flag.
`timescale 1ns / 1ps

module mbid_decode (
    input  logic [mbid_pkg::INSTR_W-1:0] instruction,
    output mbid_pkg::dec_t               dec
);
    import mbid_pkg::*;

    logic [5:0] major;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [5:0] funct;
    op_t        op;
    logic [15:0] low;

    assign major = instruction[31:26];
    assign rs    = instruction[25:21];
    assign rt    = instruction[20:16];
    assign funct = instruction[5:0];
    assign low   = instruction[15:0];

    always_comb begin
        case (major)
            MAJOR_SPECIAL: begin
                op = SPECIAL_OPS[funct];
            end
            MAJOR_REGIMM: begin
                if (rt == RT_BLTZAL) begin
                    op = OP_BLTZAL;
                end else if (rt == RT_BGEZAL) begin
                    op = OP_BGEZAL;
                end else begin
                    op = rt[0] ? OP_BGEZ : OP_BLTZ;
                end
            end
            MAJOR_COP0: begin
                if (!rs[4]) begin
                    op = COP0_MOVE_OPS[rs[3:0]];
                end else begin
                    op = (funct == FUNCT_RFE) ? OP_RFE : OP_NONE;
                end
            end
            MAJOR_COP2: begin
                if (!rs[4]) begin
                    op = COP2_MOVE_OPS[rs[3:0]];
                end else begin
                    op = COP2_CMD_OPS[funct];
                end
            end
            default: begin
                op = PRIMARY_OPS[major];
            end
        endcase
    end

    always_comb begin
        dec.op = op;
        if (op == OP_J || op == OP_JAL) begin
            dec.immediate = {6'd0, instruction[25:0]};
        end else if (op >= OP_ANDI && op <= OP_LUI) begin
            dec.immediate = {16'd0, low};
        end else if ((op >= OP_BEQ && op <= OP_SLTIU) || (op >= OP_LB && op <= OP_SWC3) ||
                     (op >= OP_BLTZ && op <= OP_BGEZAL)) begin
            dec.immediate = {{16{low[15]}}, low};
        end else begin
            dec.immediate = '0;
        end
        dec.changes_flow = (op >= OP_J && op <= OP_BGTZ) ||
                           (op >= OP_COP1 && op <= OP_INVALID) ||
                           (op >= OP_JR && op <= OP_BREAK) ||
                           (op >= OP_BLTZ && op <= OP_BGEZAL);
    end

endmodule

FILE: hw/rtl/mbid_block_track.sv
// Block-end tracking: delay-slot flag and span-boundary check.
`timescale 1ns / 1ps

module mbid_block_track #(
    parameter int BLOCK_SPAN_BYTES = mbid_pkg::BLOCK_SPAN_BYTES_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [mbid_pkg::ADDR_W-1:0] fetch_address,
    input  logic                        changes_flow,
    output logic                        block_end
);
    import mbid_pkg::*;

    localparam int SPAN_BITS = $clog2(BLOCK_SPAN_BYTES);

    logic              prev_changed_flow_reg;
    logic              prev_changed_flow_next;
    logic [ADDR_W-1:0] next_address;

    assign next_address = fetch_address + ADDR_W'(FETCH_STEP);
    assign block_end = prev_changed_flow_reg || (next_address[SPAN_BITS-1:2] == '0);

    always_comb begin
        prev_changed_flow_next = prev_changed_flow_reg;
        if (advance) begin
            prev_changed_flow_next = !block_end && changes_flow;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_changed_flow_reg <= 1'b0;
        end else begin
            prev_changed_flow_reg <= prev_changed_flow_next;
        end
    end

endmodule

FILE: hw/rtl/mips_block_instruction_decoder.sv
// Top level: input register, decode, block tracking and result register.
//
//   channel | ports                               | direction
//   s_      | s_instruction, s_fetch_address      | in, valid/ready
//   m_      | m_op .. m_block_end (11 fields)     | out, valid/ready
//
// One item per cycle sustained while m_ready is high; m_valid is registered.
// The decode sits between the input register and the result register.
// Synchronous active-low reset clears both valid flags and the delay-slot flag.
// A stalled result holds its register; the input register still takes an item
// when the result register frees in the same cycle.
`timescale 1ns / 1ps

module mips_block_instruction_decoder #(
    parameter int BLOCK_SPAN_BYTES = mbid_pkg::BLOCK_SPAN_BYTES_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mbid_pkg::INSTR_W-1:0] s_instruction,
    input  logic [mbid_pkg::ADDR_W-1:0]  s_fetch_address,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mbid_pkg::OP_W-1:0]    m_op,
    output logic [mbid_pkg::REG_W-1:0]   m_rs_index,
    output logic [mbid_pkg::REG_W-1:0]   m_rt_index,
    output logic [mbid_pkg::REG_W-1:0]   m_rd_index,
    output logic [mbid_pkg::REG_W-1:0]   m_shift_amount,
    output logic [mbid_pkg::INSTR_W-1:0] m_immediate,
    output logic                         m_gte_lm,
    output logic [mbid_pkg::SHIFT_W-1:0] m_gte_shift,
    output logic [mbid_pkg::SEL_W-1:0]   m_gte_select,
    output logic                         m_changes_flow,
    output logic                         m_block_end
);
    import mbid_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [INSTR_W-1:0] instr_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               advance;
    logic               accept;
    logic               block_end;
    dec_t               dec;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    mbid_decode u_decode (
        .instruction (instr_reg),
        .dec         (dec)
    );

    mbid_block_track #(
        .BLOCK_SPAN_BYTES (BLOCK_SPAN_BYTES)
    ) u_block_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .fetch_address (addr_reg),
        .changes_flow  (dec.changes_flow),
        .block_end     (block_end)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            instr_reg <= s_instruction;
            addr_reg  <= s_fetch_address;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_op           <= dec.op;
            m_rs_index     <= instr_reg[25:21];
            m_rt_index     <= instr_reg[20:16];
            m_rd_index     <= instr_reg[15:11];
            m_shift_amount <= instr_reg[10:6];
            m_immediate    <= dec.immediate;
            m_gte_lm       <= instr_reg[10];
            m_gte_shift    <= instr_reg[19] ? GTE_SF_SHIFT : '0;
            m_gte_select   <= instr_reg[18:13];
            m_changes_flow <= dec.changes_flow;
            m_block_end    <= block_end;
        end
    end

endmodule

FILE: test/mips_block_instruction_decoder_tb.sv
// Testbench: streams instruction words through the block decoder and checks each decoded item.
`timescale 1ns / 1ps

module mips_block_instruction_decoder_tb;

    import mbid_pkg::*;

    localparam int SPAN_BYTES   = 256;
    localparam int RANDOM_ITEMS = 1050;
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 30;

    localparam logic [ADDR_W-1:0] SPAN_MASK = ADDR_W'(SPAN_BYTES - 1) & ~ADDR_W'(3);

    localparam logic [5:0] MAJOR_J          = 6'h02;
    localparam logic [5:0] MAJOR_BEQ        = 6'h04;
    localparam logic [5:0] MAJOR_ADDI       = 6'h08;
    localparam logic [5:0] MAJOR_ANDI       = 6'h0c;
    localparam logic [5:0] MAJOR_LUI        = 6'h0f;
    localparam logic [5:0] FUNCT_SLL        = 6'h00;
    localparam logic [5:0] FUNCT_JR         = 6'h08;
    localparam logic [5:0] FUNCT_NOT_RFE    = 6'h11;
    localparam logic [5:0] FUNCT_GTE_UNUSED = 6'h02;
    localparam logic [5:0] FUNCT_RTPT       = 6'h30;
    localparam logic [4:0] RT_BLTZ_ALT      = 5'h12;
    localparam logic [4:0] RT_BGEZ_ALT      = 5'h13;
    localparam logic [4:0] RS_MTC0          = 5'h04;
    localparam logic [4:0] RS_COP_CMD       = 5'h10;

    localparam op_t PRIMARY_MAP [64] = '{
         0,  0,  1,  2,  3,  4,  5,  6,   7,  8,  9, 10, 11, 12, 13, 14,
         0, 15,  0, 16, 17, 17, 17, 17,  17, 17, 17, 17, 17, 17, 17, 17,
        18, 19, 20, 21, 22, 23, 24, 17,  25, 26, 27, 28, 17, 17, 29, 17,
        30, 31, 32, 33, 17, 17, 17, 17,  34, 35, 36, 37, 17, 17, 17, 17
    };

    localparam op_t FUNCT_MAP [64] = '{
        38, 17, 39, 40, 41, 17, 42, 43,  44, 45, 17, 17, 46, 47, 17, 17,
        48, 49, 50, 51, 17, 17, 17, 17,  52, 53, 54, 55, 17, 17, 17, 17,
        56, 57, 58, 59, 60, 61, 62, 63,  17, 17, 64, 65, 17, 17, 17, 17,
        17, 17, 17, 17, 17, 17, 17, 17,  17, 17, 17, 17, 17, 17, 17, 17
    };

    localparam op_t SYS_MOVE_MAP [16] = '{
        70, 17, 17, 17, 71, 17, 17, 17,  17, 17, 17, 17, 17, 17, 17, 17
    };

    localparam op_t GEO_MOVE_MAP [16] = '{
        73, 17, 74, 17, 75, 17, 76, 17,  17, 17, 17, 17, 17, 17, 17, 17
    };

    localparam op_t GEO_CMD_MAP [64] = '{
        77, 77,  0,  0,  0,  0, 78,  0,   0,  0,  0,  0, 79,  0,  0,  0,
        80, 81, 82, 83, 84,  0, 85,  0,   0,  0, 86, 87, 88,  0, 89,  0,
        90,  0,  0,  0,  0,  0,  0,  0,  91, 86, 92,  0,  0, 93, 94,  0,
        95,  0,  0,  0,  0,  0,  0,  0,   0,  0,  0,  0,  0, 96, 97, 98
    };

    typedef struct packed {
        op_t                op;
        logic [REG_W-1:0]   rs_index;
        logic [REG_W-1:0]   rt_index;
        logic [REG_W-1:0]   rd_index;
        logic [REG_W-1:0]   shift_amount;
        logic [INSTR_W-1:0] immediate;
        logic               gte_lm;
        logic [SHIFT_W-1:0] gte_shift;
        logic [SEL_W-1:0]   gte_select;
        logic               changes_flow;
        logic               block_end;
    } decode_result_t;

    class decode_scoreboard;
        decode_result_t pending_decodes[$];
        bit             in_delay_slot;
        int             mismatches;
        int             decodes_checked;

        function new();
            in_delay_slot = 1'b0;
            mismatches = 0;
            decodes_checked = 0;
        endfunction

        function void note_fetch(logic [INSTR_W-1:0] word, logic [ADDR_W-1:0] addr);
            decode_result_t r;
            logic [5:0] major;
            logic [5:0] funct;
            logic [4:0] rs;
            logic [4:0] rt;
            logic [ADDR_W-1:0] next_addr;
            major = word[31:26];
            funct = word[5:0];
            rs = word[25:21];
            rt = word[20:16];
            case (major)
                MAJOR_SPECIAL: r.op = FUNCT_MAP[funct];
                MAJOR_REGIMM: begin
                    if (rt == RT_BLTZAL) r.op = OP_BLTZAL;
                    else if (rt == RT_BGEZAL) r.op = OP_BGEZAL;
                    else r.op = rt[0] ? OP_BGEZ : OP_BLTZ;
                end
                MAJOR_COP0: begin
                    if (!rs[4]) r.op = SYS_MOVE_MAP[rs[3:0]];
                    else r.op = (funct == FUNCT_RFE) ? OP_RFE : OP_NONE;
                end
                MAJOR_COP2: begin
                    if (!rs[4]) r.op = GEO_MOVE_MAP[rs[3:0]];
                    else r.op = GEO_CMD_MAP[funct];
                end
                default: r.op = PRIMARY_MAP[major];
            endcase

            if (r.op == OP_J || r.op == OP_JAL)
                r.immediate = {6'd0, word[25:0]};
            else if (r.op >= OP_ANDI && r.op <= OP_LUI)
                r.immediate = {16'd0, word[15:0]};
            else if ((r.op >= OP_BEQ && r.op <= OP_SLTIU) || (r.op >= OP_LB && r.op <= OP_SWC3)
                     || (r.op >= OP_BLTZ && r.op <= OP_BGEZAL))
                r.immediate = {{16{word[15]}}, word[15:0]};
            else
                r.immediate = '0;

            r.changes_flow = (r.op >= OP_J && r.op <= OP_BGTZ)
                          || (r.op >= OP_COP1 && r.op <= OP_INVALID)
                          || (r.op >= OP_JR && r.op <= OP_BREAK)
                          || (r.op >= OP_BLTZ && r.op <= OP_BGEZAL);

            r.rs_index = rs;
            r.rt_index = rt;
            r.rd_index = word[15:11];
            r.shift_amount = word[10:6];
            r.gte_lm = word[10];
            r.gte_shift = word[19] ? GTE_SF_SHIFT : '0;
            r.gte_select = word[18:13];

            next_addr = addr + ADDR_W'(FETCH_STEP);
            r.block_end = in_delay_slot || ((next_addr & SPAN_MASK) == '0);
            in_delay_slot = !r.block_end && r.changes_flow;
            pending_decodes.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("mismatch at item %0d: %s", decodes_checked, msg);
        endtask

        task compare_field(string name, logic [INSTR_W-1:0] got, logic [INSTR_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_decode(decode_result_t got);
            decode_result_t want;
            if (pending_decodes.size() == 0) begin
                report_mismatch($sformatf("unexpected item, op %0d", got.op));
                return;
            end
            want = pending_decodes.pop_front();
            compare_field("op", 32'(got.op), 32'(want.op));
            compare_field("rs_index", 32'(got.rs_index), 32'(want.rs_index));
            compare_field("rt_index", 32'(got.rt_index), 32'(want.rt_index));
            compare_field("rd_index", 32'(got.rd_index), 32'(want.rd_index));
            compare_field("shift_amount", 32'(got.shift_amount), 32'(want.shift_amount));
            compare_field("immediate", got.immediate, want.immediate);
            compare_field("gte_lm", 32'(got.gte_lm), 32'(want.gte_lm));
            compare_field("gte_shift", 32'(got.gte_shift), 32'(want.gte_shift));
            compare_field("gte_select", 32'(got.gte_select), 32'(want.gte_select));
            compare_field("changes_flow", 32'(got.changes_flow), 32'(want.changes_flow));
            compare_field("block_end", 32'(got.block_end), 32'(want.block_end));
            decodes_checked++;
        endtask
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [INSTR_W-1:0] s_instruction = '0;
    logic [ADDR_W-1:0]  s_fetch_address = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [OP_W-1:0]    m_op;
    logic [REG_W-1:0]   m_rs_index;
    logic [REG_W-1:0]   m_rt_index;
    logic [REG_W-1:0]   m_rd_index;
    logic [REG_W-1:0]   m_shift_amount;
    logic [INSTR_W-1:0] m_immediate;
    logic               m_gte_lm;
    logic [SHIFT_W-1:0] m_gte_shift;
    logic [SEL_W-1:0]   m_gte_select;
    logic               m_changes_flow;
    logic               m_block_end;

    decode_result_t     observed;
    decode_scoreboard   sb;
    bit                 idle_on = 1'b1;
    bit                 hold_go = 1'b0;
    bit                 hold_taken = 1'b0;
    int                 hold_left = 0;
    int                 fetch_count = 0;
    int                 quiet_cycles = 0;
    logic [ADDR_W-1:0]  pc;

    assign observed = {m_op, m_rs_index, m_rt_index, m_rd_index, m_shift_amount, m_immediate,
                       m_gte_lm, m_gte_shift, m_gte_select, m_changes_flow, m_block_end};

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mips_block_instruction_decoder #(
        .BLOCK_SPAN_BYTES(SPAN_BYTES)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_instruction  (s_instruction),
        .s_fetch_address(s_fetch_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_op           (m_op),
        .m_rs_index     (m_rs_index),
        .m_rt_index     (m_rt_index),
        .m_rd_index     (m_rd_index),
        .m_shift_amount (m_shift_amount),
        .m_immediate    (m_immediate),
        .m_gte_lm       (m_gte_lm),
        .m_gte_shift    (m_gte_shift),
        .m_gte_select   (m_gte_select),
        .m_changes_flow (m_changes_flow),
        .m_block_end    (m_block_end)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_decode(observed);
            if (s_valid && s_ready) begin
                sb.note_fetch(s_instruction, s_fetch_address);
                fetch_count++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("mips_block_instruction_decoder regression: fail");
            $finish;
        end
    end

    // hold off the result side once for a long stretch so the block backs up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(idle_on && $urandom_range(0, 99) < 10);
        end
    end

    function automatic logic [INSTR_W-1:0] mk_itype(logic [5:0] major, logic [4:0] rs,
                                                   logic [4:0] rt, logic [15:0] imm);
        return {major, rs, rt, imm};
    endfunction

    function automatic logic [INSTR_W-1:0] mk_rtype(logic [5:0] major, logic [4:0] rs,
                                                   logic [4:0] rt, logic [4:0] rd,
                                                   logic [4:0] sa, logic [5:0] funct);
        return {major, rs, rt, rd, sa, funct};
    endfunction

    function automatic logic [INSTR_W-1:0] random_word();
        logic [INSTR_W-1:0] w;
        int pick;
        w = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            w[31:26] = MAJOR_SPECIAL;
        end else if (pick < 30) begin
            w[31:26] = MAJOR_REGIMM;
            if ($urandom_range(0, 2) == 0)
                w[20:16] = $urandom_range(0, 1) ? RT_BLTZAL : RT_BGEZAL;
        end else if (pick < 40) begin
            w[31:26] = MAJOR_COP0;
            if ($urandom_range(0, 2) == 0)
                w[5:0] = FUNCT_RFE;
        end else if (pick < 62) begin
            w[31:26] = MAJOR_COP2;
            if ($urandom_range(0, 4) != 0)
                w[25] = 1'b1;
            if ($urandom_range(0, 9) < 7) begin
                while (GEO_CMD_MAP[w[5:0]] == OP_NONE)
                    w[5:0] = 6'($urandom_range(0, 63));
            end
        end else if (pick < 85) begin
            w[31:26] = 6'($urandom_range(2, 63));
        end
        return w;
    endfunction

    task automatic send_item(logic [INSTR_W-1:0] word, logic [ADDR_W-1:0] addr);
        int target;
        while (idle_on && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        target = fetch_count + 1;
        s_valid <= 1'b1;
        s_instruction <= word;
        s_fetch_address <= addr;
        @(negedge aclk);
        while (fetch_count != target)
            @(negedge aclk);
    endtask

    initial begin
        int pick;
        sb = new();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        send_item('0, 29'h0);
        send_item('1, 29'h1fff_fffc);
        send_item({MAJOR_J, 26'h3ff_ffff}, 29'h100);
        send_item(mk_rtype(MAJOR_SPECIAL, 5'h1f, 5'h1f, 5'h1f, 5'h1f, FUNCT_SLL), 29'h104);
        send_item(mk_itype(MAJOR_ADDI, 5'h01, 5'h02, 16'h8000), 29'h108);
        send_item(mk_itype(MAJOR_ANDI, 5'h03, 5'h04, 16'h8000), 29'h10c);
        send_item(mk_itype(MAJOR_LUI, 5'h00, 5'h1f, 16'hffff), 29'h110);
        send_item(mk_itype(MAJOR_REGIMM, 5'h05, RT_BLTZAL, 16'h7fff), 29'h114);
        send_item(mk_itype(MAJOR_REGIMM, 5'h06, RT_BGEZAL, 16'h8001), 29'h118);
        send_item(mk_itype(MAJOR_REGIMM, 5'h07, RT_BLTZ_ALT, 16'h0000), 29'h11c);
        send_item(mk_itype(MAJOR_REGIMM, 5'h08, RT_BGEZ_ALT, 16'hffff), 29'h120);
        send_item(mk_rtype(MAJOR_COP0, RS_COP_CMD, 5'h00, 5'h00, 5'h00, FUNCT_RFE), 29'h124);
        send_item(mk_rtype(MAJOR_COP0, RS_COP_CMD, 5'h1f, 5'h1f, 5'h1f, FUNCT_NOT_RFE),
                  29'h128);
        send_item(mk_rtype(MAJOR_COP0, RS_MTC0, 5'h0c, 5'h0c, 5'h00, FUNCT_SLL), 29'h12c);
        send_item(mk_rtype(MAJOR_COP2, 5'h1f, 5'h1f, 5'h1f, 5'h1f, FUNCT_GTE_UNUSED), 29'h130);
        send_item(mk_rtype(MAJOR_COP2, RS_COP_CMD, 5'h08, 5'h00, 5'h10, FUNCT_RTPT), 29'h134);
        send_item(mk_rtype(MAJOR_SPECIAL, 5'h1f, 5'h00, 5'h00, 5'h00, FUNCT_JR), 29'h1f8);
        send_item(mk_itype(MAJOR_ADDI, 5'h00, 5'h00, 16'h0001), 29'h1fc);
        send_item(mk_itype(MAJOR_BEQ, 5'h01, 5'h02, 16'hfffe), 29'h2fc);
        send_item(mk_rtype(MAJOR_SPECIAL, 5'h00, 5'h00, 5'h00, 5'h00, FUNCT_SLL), 29'h300);
        send_item(mk_itype(MAJOR_ADDI, 5'h0a, 5'h15, 16'h5555), 29'h0fb);
        send_item(mk_itype(MAJOR_ADDI, 5'h15, 5'h0a, 16'haaaa), 29'h0fd);

        pc = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300)
                idle_on <= 1'b0;
            if (n == 550)
                idle_on <= 1'b1;
            if (n == 700)
                hold_go <= 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                pc = ADDR_W'($urandom());
            else if (pick < 8)
                pc = ADDR_W'($urandom()) & ~ADDR_W'(3);
            else if (pick < 12)
                pc = (ADDR_W'($urandom()) | SPAN_MASK) - ADDR_W'(4 * $urandom_range(0, 3));
            else
                pc = pc + ADDR_W'(FETCH_STEP);
            send_item(random_word(), pc);
        end
        s_valid <= 1'b0;

        while (sb.pending_decodes.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (sb.mismatches == 0)
            $display("mips_block_instruction_decoder regression: pass");
        else
            $display("mips_block_instruction_decoder regression: fail");
        $finish;
    end

endmodule
